>>> hw/rtl/cft_pkg.sv
`timescale 1ns / 1ps
package cft_pkg;

    localparam int CHAR_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCLOSE_CHAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_TERM_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_TERM_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_TERM_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_SPACE      = 3'd6;

    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_FIELD    = 2'd1;
    localparam logic [1:0] KIND_RECORD   = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // source of an emitted character
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_X    = 2'd1,
        SRC_ENCL = 2'd2,
        SRC_BUF  = 2'd3
    } src_t;

    typedef struct packed {
        logic       in_ready;
        logic       sel_c;
        logic       emit;
        logic [1:0] kind;
        src_t       src;
        logic       set_raw;
        logic       set_seen;
        logic       set_held;
        logic       clr_held;
        logic       push_ws;
        logic       k_inc;
        logic       clr_pending;
        logic       clr_field;
        logic       toggle_q;
        logic       set_lwd;
        logic       la_load;
        logic       la_clear;
        logic       clr_parse;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_eos;
        logic la_valid;
        logic eos;
        logic x_encl;
        logic s_pair;
        logic x_delim;
        logic x_term;
        logic x_alt;
        logic x_ws;
        logic in_q;
        logic seen;
        logic held;
        logic raw;
        logic lwd;
        logic k_lt_count;
        logic full;
        logic can_emit;
        logic stage_valid;
    } status_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        logic r;
        r = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
            c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
            c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
            c == 16'h3000;
        return r;
    endfunction

endpackage

>>> hw/rtl/cft_ifs.sv
`timescale 1ns / 1ps
interface cft_char_if import cft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_source;
    modport source (output valid, char_code, end_of_source, input ready);
    modport sink   (input valid, char_code, end_of_source, output ready);
endinterface

interface cft_tok_if import cft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [CHAR_W-1:0] field_char;
    logic              last_of_run;
    modport source (output valid, kind, field_char, last_of_run, input ready);
    modport sink   (input valid, kind, field_char, last_of_run, output ready);
endinterface

interface cft_cfg_if import cft_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CHAR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/cft_dp.sv
`timescale 1ns / 1ps
module cft_dp
    import cft_pkg::*;
#(
    parameter int PENDING_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    cft_char_if.sink      chars,
    cft_tok_if.source     tokens,
    cft_cfg_if.sink       cfg,
    input  cmd_t          cmd,
    output status_t       st
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    logic [CHAR_W-1:0] delim_reg, encl_reg, term_reg, alt_first_reg, alt_second_reg;
    logic              alt_en_reg, trim_reg;

    logic [CHAR_W-1:0] char_reg, char_next;
    logic              eos_reg, eos_next;
    logic [CHAR_W-1:0] la_char_reg, la_char_next;
    logic              la_valid_reg, la_valid_next;
    logic              in_q_reg, in_q_next;
    logic              raw_reg, raw_next;
    logic              seen_reg, seen_next;
    logic              held_reg, held_next;
    logic              lwd_reg, lwd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CHAR_W-1:0] space_buf [PENDING_DEPTH];

    logic              stage_valid_reg, stage_valid_next;
    logic [1:0]        stage_kind_reg, stage_kind_next;
    logic [CHAR_W-1:0] stage_char_reg, stage_char_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire, out_free;
    logic [CHAR_W-1:0] x, emit_char;

    assign cfg.ready    = 1'b1;
    assign chars.ready  = cmd.in_ready;
    assign in_fire      = chars.valid && cmd.in_ready;

    assign tokens.valid       = out_valid_reg;
    assign tokens.kind        = out_kind_reg;
    assign tokens.field_char  = out_char_reg;
    assign tokens.last_of_run = out_last_reg;

    assign x        = cmd.sel_c ? char_reg : la_char_reg;
    assign out_free = !out_valid_reg || tokens.ready;

    always_comb
    begin
        st             = '0;
        st.in_fire     = in_fire;
        st.in_eos      = chars.end_of_source;
        st.la_valid    = la_valid_reg;
        st.eos         = eos_reg;
        st.x_encl      = (x == encl_reg);
        st.s_pair      = !cmd.sel_c && (char_reg == encl_reg);
        st.x_delim     = (x == delim_reg);
        st.x_term      = (x == term_reg);
        st.x_alt       = alt_en_reg && !cmd.sel_c && (x == alt_first_reg) &&
                         (char_reg == alt_second_reg);
        st.x_ws        = trim_reg && is_ws(x);
        st.in_q        = in_q_reg;
        st.seen        = seen_reg;
        st.held        = held_reg;
        st.raw         = raw_reg;
        st.lwd         = lwd_reg;
        st.k_lt_count  = (k_reg < cnt_reg);
        st.full        = (cnt_reg == CW'(PENDING_DEPTH));
        st.can_emit    = !stage_valid_reg || out_free;
        st.stage_valid = stage_valid_reg;
    end

    always_comb
    begin
        case (cmd.src)
            SRC_X:    emit_char = x;
            SRC_ENCL: emit_char = encl_reg;
            SRC_BUF:  emit_char = space_buf[k_reg[IW-1:0]];
            default:  emit_char = '0;
        endcase
    end

    // parse state
    always_comb
    begin
        char_next     = char_reg;
        eos_next      = eos_reg;
        la_char_next  = la_char_reg;
        la_valid_next = la_valid_reg;
        in_q_next     = in_q_reg;
        raw_next      = raw_reg;
        seen_next     = seen_reg;
        held_next     = held_reg;
        lwd_next      = lwd_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        if (in_fire)
        begin
            char_next = chars.char_code;
            eos_next  = chars.end_of_source;
        end
        if (cmd.toggle_q)
            in_q_next = !in_q_reg;
        if (cmd.set_lwd)
            lwd_next = st.x_delim;
        if (cmd.set_raw)
            raw_next = 1'b1;
        if (cmd.set_seen)
            seen_next = 1'b1;
        if (cmd.set_held)
            held_next = 1'b1;
        if (cmd.clr_held)
            held_next = 1'b0;
        if (cmd.push_ws)
            cnt_next = cnt_reg + CW'(1);
        if (cmd.k_inc)
            k_next = k_reg + CW'(1);
        if (cmd.clr_pending)
        begin
            cnt_next = '0;
            k_next   = '0;
        end
        if (cmd.clr_field)
        begin
            raw_next  = 1'b0;
            seen_next = 1'b0;
            held_next = 1'b0;
            cnt_next  = '0;
            k_next    = '0;
        end
        if (cmd.la_load)
        begin
            la_char_next  = char_reg;
            la_valid_next = 1'b1;
        end
        if (cmd.la_clear)
            la_valid_next = 1'b0;
        if (cmd.clr_parse)
        begin
            la_char_next  = '0;
            la_valid_next = 1'b0;
            in_q_next     = 1'b0;
            lwd_next      = 1'b0;
            raw_next      = 1'b0;
            seen_next     = 1'b0;
            held_next     = 1'b0;
            cnt_next      = '0;
            k_next        = '0;
        end
    end

    // one staged result ahead of the output register, so last_of_run is known
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_kind_next  = stage_kind_reg;
        stage_char_next  = stage_char_reg;
        out_valid_next   = out_valid_reg && !tokens.ready;
        out_kind_next    = out_kind_reg;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        if (cmd.emit)
        begin
            if (stage_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = stage_kind_reg;
                out_char_next  = stage_char_reg;
                out_last_next  = 1'b0;
            end
            stage_valid_next = 1'b1;
            stage_kind_next  = cmd.kind;
            stage_char_next  = emit_char;
        end
        else if (cmd.flush && stage_valid_reg)
        begin
            out_valid_next   = 1'b1;
            out_kind_next    = stage_kind_reg;
            out_char_next    = stage_char_reg;
            out_last_next    = 1'b1;
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg      <= 16'd44;
            encl_reg       <= 16'd34;
            term_reg       <= 16'd10;
            alt_first_reg  <= 16'd13;
            alt_second_reg <= 16'd10;
            alt_en_reg     <= 1'b1;
            trim_reg       <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DELIMITER:       delim_reg      <= cfg.data;
                CFG_ENCLOSE_CHAR:    encl_reg       <= cfg.data;
                CFG_TERMINATOR:      term_reg       <= cfg.data;
                CFG_ALT_TERM_FIRST:  alt_first_reg  <= cfg.data;
                CFG_ALT_TERM_SECOND: alt_second_reg <= cfg.data;
                CFG_ALT_TERM_ENABLE: alt_en_reg     <= cfg.data[0];
                CFG_TRIM_SPACE:      trim_reg       <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eos_reg         <= 1'b0;
            la_char_reg     <= '0;
            la_valid_reg    <= 1'b0;
            in_q_reg        <= 1'b0;
            raw_reg         <= 1'b0;
            seen_reg        <= 1'b0;
            held_reg        <= 1'b0;
            lwd_reg         <= 1'b0;
            cnt_reg         <= '0;
            k_reg           <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            eos_reg         <= eos_next;
            la_char_reg     <= la_char_next;
            la_valid_reg    <= la_valid_next;
            in_q_reg        <= in_q_next;
            raw_reg         <= raw_next;
            seen_reg        <= seen_next;
            held_reg        <= held_next;
            lwd_reg         <= lwd_next;
            cnt_reg         <= cnt_next;
            k_reg           <= k_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        stage_kind_reg <= stage_kind_next;
        stage_char_reg <= stage_char_next;
        out_kind_reg   <= out_kind_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        if (cmd.push_ws)
            space_buf[cnt_reg[IW-1:0]] <= x;
    end

endmodule

>>> hw/rtl/cft_ctrl.sv
`timescale 1ns / 1ps
module cft_ctrl
    import cft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_JUDGE = 5'b00010,
        S_ADD   = 5'b00100,
        S_FIN   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   pend_reg, pend_next;

    logic is_add, is_toggle, is_end, used, need_emit;

    always_comb
    begin
        is_toggle = st.x_encl && !st.s_pair;
        is_add    = st.x_encl ? st.s_pair
                              : (st.in_q || !(st.x_delim || st.x_term || st.x_alt));
        is_end    = !st.x_encl && !st.in_q && (st.x_delim || st.x_term || st.x_alt);
        used      = (st.x_encl && st.s_pair) || (is_end && !st.x_delim && !st.x_term);
        need_emit = is_end ||
                    (is_add && st.x_ws && st.seen && st.full) ||
                    (is_add && !st.x_ws && !st.seen && !st.x_encl);
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel_c  = sel_reg;
        cmd.src    = SRC_NONE;
        state_next = state_reg;
        sel_next   = sel_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_fire)
                begin
                    pend_next = 1'b1;
                    if (st.la_valid)
                    begin
                        sel_next   = 1'b0;
                        state_next = S_JUDGE;
                    end
                    else if (st.in_eos)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_JUDGE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_JUDGE:
            begin
                // hold until the result path has room
                if (!need_emit || st.can_emit)
                begin
                    cmd.set_lwd  = 1'b1;
                    cmd.toggle_q = is_toggle;
                    if (used)
                        pend_next = 1'b0;
                    if (is_end)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.kind      = st.x_delim ? KIND_FIELD : KIND_RECORD;
                        cmd.clr_field = 1'b1;
                    end
                    else if (is_add)
                    begin
                        cmd.set_raw = 1'b1;
                        if (st.x_ws)
                        begin
                            if (st.seen && st.full)
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = KIND_OVERFLOW;
                            end
                            else if (st.seen)
                            begin
                                cmd.push_ws = 1'b1;
                            end
                        end
                        else if (!st.seen)
                        begin
                            cmd.set_seen = 1'b1;
                            if (st.x_encl)
                            begin
                                cmd.set_held = 1'b1;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = KIND_CHAR;
                                cmd.src  = SRC_X;
                            end
                        end
                    end
                    if (is_add && !st.x_ws && st.seen)
                        state_next = S_ADD;
                    else if (sel_reg)
                        state_next = S_FIN;
                    else if (st.eos && !used)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_JUDGE;
                    end
                    else if (st.eos)
                        state_next = S_FIN;
                    else
                        state_next = S_DONE;
                end
            end
            S_ADD:
            begin
                // release held enclose char, then held spaces, then the char
                if (st.can_emit)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_CHAR;
                    if (st.held)
                    begin
                        cmd.src      = SRC_ENCL;
                        cmd.clr_held = 1'b1;
                    end
                    else if (st.k_lt_count)
                    begin
                        cmd.src   = SRC_BUF;
                        cmd.k_inc = 1'b1;
                    end
                    else
                    begin
                        cmd.src         = SRC_X;
                        cmd.clr_pending = 1'b1;
                        if (sel_reg)
                            state_next = S_FIN;
                        else if (st.eos && pend_reg)
                        begin
                            sel_next   = 1'b1;
                            state_next = S_JUDGE;
                        end
                        else if (st.eos)
                            state_next = S_FIN;
                        else
                            state_next = S_DONE;
                    end
                end
            end
            S_FIN:
            begin
                if (st.raw || st.in_q || st.lwd)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.kind      = KIND_RECORD;
                        cmd.clr_field = 1'b1;
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (st.can_emit)
                begin
                    cmd.flush = 1'b1;
                    if (st.eos)
                        cmd.clr_parse = 1'b1;
                    else if (pend_reg)
                        cmd.la_load = 1'b1;
                    else
                        cmd.la_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> hw/rtl/csv_field_tokenizer.sv
`timescale 1ns / 1ps
// CSV field tokenizer over UTF-16 code units. Each character is held one item
// so it can be judged with its follower (doubled enclose char, two-character
// alternative terminator). Results on tokens are field characters, field ends,
// record ends and whitespace-overflow marks; last_of_run flags the final result
// of each input item. An item that only fills the lookahead goes straight to
// the final step. Otherwise the state machine judges the character; one that
// joins a field that has already begun follows the held characters it releases
// (held enclose char and held whitespace, up to PENDING_DEPTH), and at end
// of source it checks for the closing record. The state machine runs these
// steps, one result per cycle, and waits whenever the output register is full.
// Configuration writes are taken any cycle and must only occur while idle.
module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int PENDING_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    cft_char_if.sink  chars,
    cft_tok_if.source tokens,
    cft_cfg_if.sink   cfg
);

    cmd_t    cmd;
    status_t st;

    cft_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    cft_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .tokens (tokens),
        .cfg    (cfg),
        .cmd    (cmd),
        .st     (st)
    );

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.can_emit)
        else $error("result emitted with no room");

    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.in_ready |-> !st.stage_valid)
        else $error("new item accepted with a staged result left over");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_ws |-> !st.full)
        else $error("whitespace pushed into full buffer");

endmodule
